### design/primitive_to_triangle_list_top_defines.svh
// Assertion macros for the primitive-to-triangle-list design files (used by p2t_emit).
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef PRIMITIVE_TO_TRIANGLE_LIST_TOP_DEFINES_SVH
`define PRIMITIVE_TO_TRIANGLE_LIST_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge, ignored while reset is high.
`define P2T_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define P2T_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define P2T_ASSERT(label, prop, msg)
`define P2T_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### design/p2t_pkg.sv
// Shared types and constants for the primitive-to-triangle-list block.
// No dependencies; imported by every module of the block.
package p2t_pkg;

   localparam int VERTEX_W              = 64;
   localparam int PAYLOAD_WIDTH_DEFAULT = 64;
   localparam int MAX_ITEMS             = 5;
   localparam int HIST_DEPTH            = 5;
   localparam int CNT_W                 = 3;
   localparam int ITEMS_W               = $clog2(MAX_ITEMS + 1);

   typedef enum logic [2:0] {
      MODE_QUADS      = 3'd0,
      MODE_QUAD_STRIP = 3'd1,
      MODE_TRI_STRIP  = 3'd2,
      MODE_TRI_FAN    = 3'd3,
      MODE_PASS       = 3'd4
   } mode_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex_data;
      logic                restart;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] out_vertex;
      logic                last;
   } rsp_type;

   // Hand-over of one assembled item list from the assembler to the emitter.
   typedef struct packed {
      logic               load;
      logic [ITEMS_W-1:0] num_items;
   } load_ctrl_type;

endpackage

### design/p2t_assemble.sv
// Input register, vertex count, mode register and emit history; builds the
// full list of output items for one input vertex. Depends on p2t_pkg.
module p2t_assemble
   import p2t_pkg::*;
#(
   parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   input  logic                     csr_wr_en,
   input  logic [2:0]               csr_wr_data,
   input  logic                     can_load,
   output load_ctrl_type            load_ctrl,
   output logic [PAYLOAD_WIDTH-1:0] items [MAX_ITEMS]
);

   logic                     in_valid_ff, in_valid_in;
   logic [PAYLOAD_WIDTH-1:0] in_data_ff;
   logic                     in_restart_ff;
   mode_type                 mode_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [PAYLOAD_WIDTH-1:0] hist_ff [HIST_DEPTH];
   logic [PAYLOAD_WIDTH-1:0] hist_in [HIST_DEPTH];

   logic                     go;
   logic                     accept;
   logic [CNT_W-1:0]         cnt_base;
   logic [CNT_W:0]           cnt_sum;
   logic [CNT_W-1:0]         cnt;
   logic [2:0]               n_rep;
   logic [PAYLOAD_WIDTH-1:0] rep [4];

   assign go        = in_valid_ff && can_load;
   assign req_ready = !in_valid_ff || go;
   assign accept    = req_valid && req_ready;

   assign in_valid_in = accept || (in_valid_ff && !go);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_PASS;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            mode_ff <= mode_type'(csr_wr_data);
         end
         if (go) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff    <= req_data.vertex_data[PAYLOAD_WIDTH-1:0];
         in_restart_ff <= req_data.restart;
      end
   end

   // The history is reset to zero because early repeats read it before it fills.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (go) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

   // Repeat offsets count back through copies already emitted for the same
   // vertex, so each copy resolves to a fixed slot of the stored history.
   always_comb begin
      cnt_base = in_restart_ff ? '0 : count_ff;
      cnt_sum  = {1'b0, cnt_base} + (CNT_W+1)'(1);
      cnt      = (cnt_sum > (CNT_W+1)'(6)) ? CNT_W'(5) : cnt_sum[CNT_W-1:0];
      count_in = cnt;
      n_rep    = 3'd0;
      for (int i = 0; i < 4; i++) begin
         rep[i] = '0;
      end
      case (mode_ff)
         MODE_QUADS: begin
            if (cnt == CNT_W'(4)) begin
               count_in = '0;
               n_rep    = 3'd2;
               rep[0]   = hist_ff[2];
               rep[1]   = hist_ff[0];
            end
         end
         MODE_QUAD_STRIP: begin
            if (cnt == CNT_W'(4)) begin
               n_rep  = 3'd2;
               rep[0] = hist_ff[0];
               rep[1] = hist_ff[1];
            end else if (cnt == CNT_W'(6)) begin
               n_rep  = 3'd4;
               rep[0] = hist_ff[3];
               rep[1] = hist_ff[1];
               rep[2] = hist_ff[0];
               rep[3] = hist_ff[1];
            end
         end
         MODE_TRI_STRIP: begin
            if (cnt > CNT_W'(3)) begin
               n_rep = 3'd2;
               if (cnt[0]) begin
                  rep[0] = hist_ff[2];
                  rep[1] = hist_ff[0];
               end else begin
                  rep[0] = hist_ff[0];
                  rep[1] = hist_ff[1];
               end
            end
         end
         MODE_TRI_FAN: begin
            if (cnt > CNT_W'(3)) begin
               n_rep  = 3'd2;
               rep[0] = hist_ff[2];
               rep[1] = hist_ff[0];
            end
         end
         default: begin
            n_rep = 3'd0;
         end
      endcase

      // Emission order: repeats first, then the current vertex.
      for (int i = 0; i < MAX_ITEMS; i++) begin
         items[i] = '0;
      end
      case (n_rep)
         3'd2: begin
            items[0]   = rep[0];
            items[1]   = rep[1];
            items[2]   = in_data_ff;
            hist_in[0] = in_data_ff;
            hist_in[1] = rep[1];
            hist_in[2] = rep[0];
            hist_in[3] = hist_ff[0];
            hist_in[4] = hist_ff[1];
         end
         3'd4: begin
            items[0]   = rep[0];
            items[1]   = rep[1];
            items[2]   = rep[2];
            items[3]   = rep[3];
            items[4]   = in_data_ff;
            hist_in[0] = in_data_ff;
            hist_in[1] = rep[3];
            hist_in[2] = rep[2];
            hist_in[3] = rep[1];
            hist_in[4] = rep[0];
         end
         default: begin
            items[0]   = in_data_ff;
            hist_in[0] = in_data_ff;
            hist_in[1] = hist_ff[0];
            hist_in[2] = hist_ff[1];
            hist_in[3] = hist_ff[2];
            hist_in[4] = hist_ff[3];
         end
      endcase

      load_ctrl.load      = go;
      load_ctrl.num_items = ITEMS_W'(n_rep) + ITEMS_W'(1);
   end

endmodule

### design/p2t_emit.sv
// Output buffer: holds one assembled item list and shifts it out one
// transaction per cycle while rsp_ready is high on the result channel. Depends on p2t_pkg.
`include "primitive_to_triangle_list_top_defines.svh"

module p2t_emit
   import p2t_pkg::*;
#(
   parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  load_ctrl_type            load_ctrl,
   input  logic [PAYLOAD_WIDTH-1:0] items [MAX_ITEMS],
   output logic                     can_load,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data
);

   logic [ITEMS_W-1:0]       remain_ff, remain_in;
   logic [PAYLOAD_WIDTH-1:0] buf_ff [MAX_ITEMS];
   logic [PAYLOAD_WIDTH-1:0] buf_in [MAX_ITEMS];
   logic                     taken;
   logic                     final_item;
   logic                     load_count_ok;
   logic                     drain_only;

   assign rsp_valid  = (remain_ff != '0);
   assign final_item = (remain_ff == ITEMS_W'(1));
   assign taken      = rsp_valid && rsp_ready;
   // A new list may enter as the last item of the current one leaves.
   assign can_load   = !rsp_valid || (taken && final_item);

   assign rsp_data.out_vertex = VERTEX_W'(buf_ff[0]);
   assign rsp_data.last       = final_item;

   assign load_count_ok = (load_ctrl.num_items == ITEMS_W'(1)) ||
                          (load_ctrl.num_items == ITEMS_W'(3)) ||
                          (load_ctrl.num_items == ITEMS_W'(5));
   assign drain_only    = taken && final_item && !load_ctrl.load;

   always_comb begin
      remain_in = remain_ff;
      for (int i = 0; i < MAX_ITEMS; i++) begin
         buf_in[i] = buf_ff[i];
      end
      if (load_ctrl.load) begin
         remain_in = load_ctrl.num_items;
         for (int i = 0; i < MAX_ITEMS; i++) begin
            buf_in[i] = items[i];
         end
      end else if (taken) begin
         remain_in = remain_ff - ITEMS_W'(1);
         for (int i = 0; i < MAX_ITEMS - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
      end else begin
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ITEMS; i++) begin
         buf_ff[i] <= buf_in[i];
      end
   end

   `P2T_ASSERT(a_load_when_free, load_ctrl.load |-> can_load, "list loaded while buffer busy")
   `P2T_ASSERT(a_load_count, load_ctrl.load |-> load_count_ok, "bad item count")
   `P2T_ASSERT(a_drain_idle, drain_only |=> !rsp_valid, "result after final transaction")
   `P2T_ASSERT(a_remain_range, remain_ff <= ITEMS_W'(MAX_ITEMS), "buffer count out of range")

endmodule

### design/primitive_to_triangle_list_top.sv
// Top level of the primitive-to-triangle-list block: assembler and emitter.
// Depends on p2t_pkg, p2t_assemble and p2t_emit.
//
//   channel | ports                       | carries
//   --------+-----------------------------+-------------------------------
//   request | req_valid/req_ready/req_data| one vertex and its restart flag
//   result  | rsp_valid/rsp_ready/rsp_data| one emitted vertex, last flag
//   config  | csr_wr_en/csr_wr_data       | primitive mode, no read-back
//
// Each vertex yields one, three or five result transactions, one per cycle
// while rsp_ready is high, through the single output buffer.
// A one-entry input register takes the next vertex while results drain.
// Reset is synchronous: mode returns to pass through, count and history clear.
// A stalled result channel holds the buffer and then the input register.
module primitive_to_triangle_list_top
   import p2t_pkg::*;
#(
   parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_wr_data
);

   load_ctrl_type            load_ctrl;
   logic                     can_load;
   logic [PAYLOAD_WIDTH-1:0] items [MAX_ITEMS];

   p2t_assemble #(
      .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
   ) u_assemble (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .can_load    (can_load),
      .load_ctrl   (load_ctrl),
      .items       (items)
   );

   p2t_emit #(
      .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .load_ctrl (load_ctrl),
      .items     (items),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
